// ----- src/sdrv_pkg.sv -----
// ----------------------------------------------------------------------------
// sdrv_pkg
// Shared types and constants for the proportional steering drive unit.
// ----------------------------------------------------------------------------
package sdrv_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_MIN_DUTY    = 3'd1,
    REG_LOW_DUTY    = 3'd2,
    REG_HIGH_DUTY   = 3'd3,
    REG_INVERT_DIR  = 3'd4,
    REG_TIMEOUT_MS  = 3'd5,
    REG_WORK_MODE   = 3'd6,
    REG_STEER_MODE  = 3'd7
  } reg_idx_t;

  // Steer switch modes (code 3 unused: flag holds)
  localparam logic [1:0] STEER_NONE   = 2'd0;
  localparam logic [1:0] STEER_BUTTON = 2'd1;
  localparam logic [1:0] STEER_SWITCH = 2'd2;

  localparam int CFG_DATA_W = 16;

  // floor(x/100) = (x * RECIP100) >> 31, exact for x < 2^24
  localparam int             Q_LSB    = 31;
  localparam logic [32:0]    RECIP100 = 33'd21474837;
  // floor(x/500) = (x * RECIP500) >> 26, exact for x < 2^17
  localparam int             RAMP_LSB = 26;
  localparam int             RECIP500 = 134218;
  localparam int             RAMP_CD  = 500;

  localparam logic [31:0] LOCKOUT_MS = 32'd50;

  localparam logic [7:0]  HIGH_DUTY_RST = 8'd255;
  localparam logic [15:0] TIMEOUT_RST   = 16'd1000;
  localparam logic [25:0] RAMP_K_RST    = 26'(255 * RECIP500);

  // Configuration as seen by the datapath, with pre-scaled gains
  typedef struct packed {
    logic [32:0] gain_scaled;   // prop_gain * RECIP100
    logic [7:0]  min_duty;
    logic [7:0]  low_duty;
    logic [7:0]  high_duty;
    logic [25:0] ramp_k;        // |high - low| * RECIP500
    logic        ramp_neg;      // high < low
    logic        invert_dir;
    logic [15:0] timeout_ms;
    logic        work_mode;
    logic [1:0]  steer_mode;
  } cfg_t;

  // Status from the guidance / switch state
  typedef struct packed {
    logic        guidance;
    logic        work_bit;
    logic        steer_bit;
  } status_t;

endpackage

// ----- src/sdrv_cfg.sv -----
// ----------------------------------------------------------------------------
// sdrv_cfg
// Configuration register file; keeps reciprocal-scaled gains alongside.
// ----------------------------------------------------------------------------
module sdrv_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [2:0]                         wr_index,
  input  logic [sdrv_pkg::CFG_DATA_W-1:0]    wr_data,
  output sdrv_pkg::cfg_t                     cfg
);
  import sdrv_pkg::*;

  cfg_t        cfg_r;
  logic [7:0]  low_new;
  logic [7:0]  high_new;
  logic        neg_new;
  logic [7:0]  span;
  reg_idx_t    idx;

  assign idx      = reg_idx_t'(wr_index);
  assign low_new  = (idx == REG_LOW_DUTY)  ? wr_data[7:0] : cfg_r.low_duty;
  assign high_new = (idx == REG_HIGH_DUTY) ? wr_data[7:0] : cfg_r.high_duty;
  assign neg_new  = high_new < low_new;
  assign span     = neg_new ? (low_new - high_new) : (high_new - low_new);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_scaled <= '0;
      cfg_r.min_duty    <= '0;
      cfg_r.low_duty    <= '0;
      cfg_r.high_duty   <= HIGH_DUTY_RST;
      cfg_r.ramp_k      <= RAMP_K_RST;
      cfg_r.ramp_neg    <= 1'b0;
      cfg_r.invert_dir  <= 1'b0;
      cfg_r.timeout_ms  <= TIMEOUT_RST;
      cfg_r.work_mode   <= 1'b0;
      cfg_r.steer_mode  <= STEER_NONE;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:  cfg_r.gain_scaled <= 33'(wr_data[7:0]) * RECIP100;
        REG_MIN_DUTY:   cfg_r.min_duty    <= wr_data[7:0];
        REG_LOW_DUTY, REG_HIGH_DUTY: begin
          cfg_r.low_duty  <= low_new;
          cfg_r.high_duty <= high_new;
          cfg_r.ramp_neg  <= neg_new;
          cfg_r.ramp_k    <= 26'(span) * 26'(RECIP500);
        end
        REG_INVERT_DIR: cfg_r.invert_dir  <= wr_data[0];
        REG_TIMEOUT_MS: cfg_r.timeout_ms  <= wr_data[15:0];
        REG_WORK_MODE:  cfg_r.work_mode   <= wr_data[0];
        REG_STEER_MODE: cfg_r.steer_mode  <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/sdrv_state.sv -----
// ----------------------------------------------------------------------------
// sdrv_state
// Held guidance message with timeout, work bit and steer switch bit.
// ----------------------------------------------------------------------------
module sdrv_state (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  sdrv_pkg::cfg_t      cfg,
  input  logic [31:0]         now_ms,
  input  logic                new_data,
  input  logic                data_guidance,
  input  logic signed [15:0]  data_setpoint_cd,
  input  logic [31:0]         data_stamp_ms,
  input  logic                work_pin,
  input  logic                steer_pin,
  output logic signed [15:0]  setpoint_cd,
  output sdrv_pkg::status_t   status
);
  import sdrv_pkg::*;

  logic signed [15:0] held_setpoint_r;
  logic               held_guidance_r;
  logic [31:0]        held_stamp_r;
  logic [31:0]        last_toggle_r, last_toggle_nxt;
  logic               prev_pressed_r, prev_pressed_nxt;
  logic               work_r, work_nxt;
  logic               steer_r, steer_nxt;

  logic               guid_raw;
  logic [31:0]        stamp;
  logic [31:0]        age;
  logic               guid_nxt;
  logic               pressed;
  logic [31:0]        since_toggle;

  // A fresh message replaces the held one before the age check
  assign guid_raw    = new_data ? data_guidance    : held_guidance_r;
  assign stamp       = new_data ? data_stamp_ms    : held_stamp_r;
  assign setpoint_cd = new_data ? data_setpoint_cd : held_setpoint_r;
  assign age         = now_ms - stamp;
  assign guid_nxt    = guid_raw && !(age > 32'(cfg.timeout_ms));

  assign work_nxt     = cfg.work_mode ? work_pin : work_r;
  assign pressed      = !steer_pin;
  assign since_toggle = now_ms - last_toggle_r;

  always_comb begin
    steer_nxt        = steer_r;
    last_toggle_nxt  = last_toggle_r;
    prev_pressed_nxt = prev_pressed_r;
    case (cfg.steer_mode)
      STEER_BUTTON: begin
        if (pressed && !prev_pressed_r && (since_toggle > LOCKOUT_MS)) begin
          steer_nxt       = !steer_r;
          last_toggle_nxt = now_ms;
        end
        prev_pressed_nxt = pressed;
      end
      STEER_SWITCH: begin
        if (steer_pin != steer_r) begin
          steer_nxt       = steer_pin;
          last_toggle_nxt = now_ms;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_setpoint_r <= '0;
      held_guidance_r <= 1'b0;
      held_stamp_r    <= '0;
      last_toggle_r   <= '0;
      prev_pressed_r  <= 1'b0;
      work_r          <= 1'b0;
      steer_r         <= 1'b1;
    end else if (advance) begin
      held_setpoint_r <= setpoint_cd;
      held_guidance_r <= guid_nxt;
      held_stamp_r    <= stamp;
      last_toggle_r   <= last_toggle_nxt;
      prev_pressed_r  <= prev_pressed_nxt;
      work_r          <= work_nxt;
      steer_r         <= steer_nxt;
    end
  end

  assign status.guidance  = guid_nxt;
  assign status.work_bit  = work_nxt;
  assign status.steer_bit = steer_nxt;

endmodule

// ----- src/sdrv_duty.sv -----
// ----------------------------------------------------------------------------
// sdrv_duty
// P term, duty ramp limit and direction from setpoint and wheel angle.
// ----------------------------------------------------------------------------
module sdrv_duty (
  input  sdrv_pkg::cfg_t      cfg,
  input  logic signed [15:0]  setpoint_cd,
  input  logic signed [15:0]  actual_cd,
  output logic [7:0]          duty,
  output logic                dir
);
  import sdrv_pkg::*;

  logic signed [16:0] err;
  logic               err_neg;
  logic [16:0]        err_abs17;
  logic [15:0]        aerr;
  logic [48:0]        p_prod;
  logic [17:0]        q;
  logic [17:0]        sat_max;
  logic [15:0]        p_mag;
  logic [16:0]        mag;
  logic               in_ramp;
  logic [8:0]         ramp_t;
  logic [34:0]        ramp_prod;
  logic [7:0]         ramp_frac;
  logic [7:0]         ramp_base;
  logic [7:0]         limit;

  assign err       = 17'(setpoint_cd) - 17'(actual_cd);
  assign err_neg   = err[16];
  assign err_abs17 = err_neg ? 17'(-err) : 17'(err);
  assign aerr      = err_abs17[15:0];

  // |err| * gain / 100, truncated, by reciprocal multiply
  assign p_prod  = 49'(aerr) * 49'(cfg.gain_scaled);
  assign q       = p_prod[Q_LSB +: 18];
  assign sat_max = err_neg ? 18'd32768 : 18'd32767;
  assign p_mag   = (q > sat_max) ? sat_max[15:0] : q[15:0];
  assign mag     = 17'(p_mag) + 17'(cfg.min_duty);

  // P > 1 only for positive error with a quotient of two or more
  assign dir = (!err_neg && (q >= 18'd2)) ^ cfg.invert_dir;

  // Ramp limit; a falling ramp is measured back from the high end so the
  // floor stays on a non-negative product
  assign in_ramp   = aerr < 16'(RAMP_CD);
  assign ramp_t    = cfg.ramp_neg ? (9'(RAMP_CD) - aerr[8:0]) : aerr[8:0];
  assign ramp_prod = 35'(ramp_t) * 35'(cfg.ramp_k);
  assign ramp_frac = ramp_prod[RAMP_LSB +: 8];
  assign ramp_base = cfg.ramp_neg ? cfg.high_duty : cfg.low_duty;
  assign limit     = in_ramp ? (ramp_base + ramp_frac) : cfg.high_duty;

  assign duty = (mag > 17'(limit)) ? limit : mag[7:0];

endmodule

// ----- src/steer_motor_p_drive_unit.sv -----
// ----------------------------------------------------------------------------
// steer_motor_p_drive_unit
// Proportional steering drive: one control tick in, one bridge command out.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Carries
//   --------+-----------+--------------------+--------------------------------
//   in_     | into unit | in_valid/in_ready  | tick time, guidance msg, angle,
//           |           |                    | work and steer pin levels
//   out_    | from unit | out_valid/out_ready| duty, enable, dir A/B, switch
//           |           |                    | bits, angle echo
//   cfg_    | into unit | cfg_valid/cfg_ready| register index and write data
//
// A tick transfer lands in the input register; from there it passes
// through the duty and switch logic into the result register once that
// register is free or being emptied, and the result is offered from the
// result register. One tick per cycle is sustained while out_ready stays
// high; the cycle is set by the P-term multiply and duty clamp path.
// Synchronous active-low reset restores the register defaults and clears
// the held guidance. With out_ready low the result register holds and one
// more tick waits in the input register before in_ready drops.
// cfg_ready is always high; writes take effect at the next edge.
//
module steer_motor_p_drive_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tick input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [31:0]                          in_now_ms,
  input  logic                                 in_new_data,
  input  logic                                 in_data_guidance,
  input  logic signed [15:0]                   in_data_setpoint_cd,
  input  logic [31:0]                          in_data_stamp_ms,
  input  logic signed [15:0]                   in_actual_angle_cd,
  input  logic                                 in_work_pin,
  input  logic                                 in_steer_pin,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_pwm_duty,
  output logic                                 out_drive_enable,
  output logic                                 out_dir_a,
  output logic                                 out_dir_b,
  output logic                                 out_work_bit,
  output logic                                 out_steer_bit,
  output logic signed [15:0]                   out_angle_echo_cd,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [2:0]                           cfg_index,
  input  logic [sdrv_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sdrv_pkg::*;

  cfg_t               cfg;
  status_t            status;

  // input register
  logic               in_valid_r;
  logic [31:0]        now_ms_r;
  logic               new_data_r;
  logic               data_guidance_r;
  logic signed [15:0] data_setpoint_r;
  logic [31:0]        data_stamp_r;
  logic signed [15:0] actual_r;
  logic               work_pin_r;
  logic               steer_pin_r;

  // result register
  logic               out_valid_r;
  logic [7:0]         pwm_duty_r;
  logic               drive_enable_r;
  logic               dir_a_r;
  logic               dir_b_r;
  logic               work_bit_r;
  logic               steer_bit_r;
  logic signed [15:0] angle_echo_r;

  logic               in_xfer;
  logic               advance;
  logic signed [15:0] setpoint_cd;
  logic [7:0]         duty;
  logic               dir;

  assign cfg_ready = 1'b1;

  // Tick moves to the result register whenever that register is free
  // or being emptied in the same cycle
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  sdrv_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sdrv_state u_state (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .cfg              (cfg),
    .now_ms           (now_ms_r),
    .new_data         (new_data_r),
    .data_guidance    (data_guidance_r),
    .data_setpoint_cd (data_setpoint_r),
    .data_stamp_ms    (data_stamp_r),
    .work_pin         (work_pin_r),
    .steer_pin        (steer_pin_r),
    .setpoint_cd      (setpoint_cd),
    .status           (status)
  );

  sdrv_duty u_duty (
    .cfg         (cfg),
    .setpoint_cd (setpoint_cd),
    .actual_cd   (actual_r),
    .duty        (duty),
    .dir         (dir)
  );

  // handshake control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_ms_r        <= in_now_ms;
      new_data_r      <= in_new_data;
      data_guidance_r <= in_data_guidance;
      data_setpoint_r <= in_data_setpoint_cd;
      data_stamp_r    <= in_data_stamp_ms;
      actual_r        <= in_actual_angle_cd;
      work_pin_r      <= in_work_pin;
      steer_pin_r     <= in_steer_pin;
    end
    if (advance) begin
      // bridge fully off without guidance
      pwm_duty_r     <= status.guidance ? duty : 8'd0;
      drive_enable_r <= status.guidance;
      dir_a_r        <= status.guidance && dir;
      dir_b_r        <= status.guidance && !dir;
      work_bit_r     <= status.work_bit;
      steer_bit_r    <= status.steer_bit;
      angle_echo_r   <= actual_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pwm_duty      = pwm_duty_r;
  assign out_drive_enable  = drive_enable_r;
  assign out_dir_a         = dir_a_r;
  assign out_dir_b         = dir_b_r;
  assign out_work_bit      = work_bit_r;
  assign out_steer_bit     = steer_bit_r;
  assign out_angle_echo_cd = angle_echo_r;

endmodule

// ----- src/sdrv_checker.sv -----
// ----------------------------------------------------------------------------
// sdrv_checker
// Port-level checks on the steering drive results, bound to the top level.
// ----------------------------------------------------------------------------
module sdrv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pwm_duty,
  input logic       out_drive_enable,
  input logic       out_dir_a,
  input logic       out_dir_b
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pwm_duty)
      && $stable(out_drive_enable) && $stable(out_dir_a))
    else $error("result changed while stalled");

  // bridge off carries no duty and no direction
  a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drive_enable |->
      out_pwm_duty == 8'd0 && !out_dir_a && !out_dir_b)
    else $error("drive disabled but duty or direction set");

  // driving bridge halves are always opposite
  a_dir_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_enable |-> out_dir_a != out_dir_b)
    else $error("bridge inputs not complementary");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind steer_motor_p_drive_unit sdrv_checker u_sdrv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_pwm_duty     (out_pwm_duty),
  .out_drive_enable (out_drive_enable),
  .out_dir_a        (out_dir_a),
  .out_dir_b        (out_dir_b)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - steer_motor_p_drive_unit testbench
// Drives 10 ms control ticks through the valid/ready input channel and checks
// every bridge command that comes back against a cycle-free model of the
// steering drive kept in this module. The configuration is changed only with
// the unit drained, across several settings including the extremes.
// ----------------------------------------------------------------------------
module tb;
  import sdrv_pkg::*;

  // Selector code 3 is unused by the unit: the steer flag simply holds
  localparam logic [1:0] STEER_UNUSED = 2'd3;
  localparam int         PHASE_TICKS  = 245;
  localparam int         HOLD_CYCLES  = 60;

  // One control tick as seen on the in_ channel
  typedef struct packed {
    logic [31:0]        now_ms;
    logic               new_data;
    logic               guidance;
    logic signed [15:0] setpoint;
    logic [31:0]        stamp;
    logic signed [15:0] actual;
    logic               work_pin;
    logic               steer_pin;
  } tick_t;

  // One bridge command as seen on the out_ channel
  typedef struct packed {
    logic [7:0]  pwm_duty;
    logic        drive_enable;
    logic        dir_a;
    logic        dir_b;
    logic        work_bit;
    logic        steer_bit;
    logic [15:0] angle_echo;
  } cmd_t;

  // Register file contents as the drive sees them
  typedef struct packed {
    logic [7:0]  gain;
    logic [7:0]  min_duty;
    logic [7:0]  low_duty;
    logic [7:0]  high_duty;
    logic        invert;
    logic [15:0] timeout;
    logic        work_mode;
    logic [1:0]  steer_mode;
  } setting_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports (all inputs known from time zero)
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        in_now_ms = '0;
  logic               in_new_data = 1'b0;
  logic               in_data_guidance = 1'b0;
  logic signed [15:0] in_data_setpoint_cd = '0;
  logic [31:0]        in_data_stamp_ms = '0;
  logic signed [15:0] in_actual_angle_cd = '0;
  logic               in_work_pin = 1'b0;
  logic               in_steer_pin = 1'b1;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_pwm_duty;
  logic               out_drive_enable;
  logic               out_dir_a;
  logic               out_dir_b;
  logic               out_work_bit;
  logic               out_steer_bit;
  logic signed [15:0] out_angle_echo_cd;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  steer_motor_p_drive_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_now_ms           (in_now_ms),
    .in_new_data         (in_new_data),
    .in_data_guidance    (in_data_guidance),
    .in_data_setpoint_cd (in_data_setpoint_cd),
    .in_data_stamp_ms    (in_data_stamp_ms),
    .in_actual_angle_cd  (in_actual_angle_cd),
    .in_work_pin         (in_work_pin),
    .in_steer_pin        (in_steer_pin),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pwm_duty        (out_pwm_duty),
    .out_drive_enable    (out_drive_enable),
    .out_dir_a           (out_dir_a),
    .out_dir_b           (out_dir_b),
    .out_work_bit        (out_work_bit),
    .out_steer_bit       (out_steer_bit),
    .out_angle_echo_cd   (out_angle_echo_cd),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Drive model state: its own copy of the registers and of the held data.
  // Values match the unit's reset defaults.
  // --------------------------------------------------------------------------
  setting_t           drv_set = '{8'd0, 8'd0, 8'd0, HIGH_DUTY_RST, 1'b0,
                                  TIMEOUT_RST, 1'b0, STEER_NONE};
  logic               hold_on     = 1'b0;   // guidance currently active
  logic signed [15:0] hold_sp     = '0;
  logic [31:0]        hold_stamp  = '0;
  logic [31:0]        toggle_ms   = '0;     // time of last steer flag change
  logic               was_pressed = 1'b0;
  logic               work_state  = 1'b0;
  logic               steer_state = 1'b1;   // 1 = steering off

  // Test bookkeeping
  tick_t tick_backlog[$];   // ticks waiting to be offered
  cmd_t  cmd_due[$];        // commands predicted for ticks already taken
  tick_t tick_offered;
  int    tx_gap = 0;
  bit    tx_busy;
  int    rx_stall = 0;
  int    rx_hold_left = 0;  // long receiver hold-off, counts down per cycle
  bit    tx_idle_en = 1'b1;
  bit    rx_idle_en = 1'b1;
  bit    tx_pause = 1'b0;
  int    fault_count = 0;
  int    ticks_taken = 0;
  int    cmds_checked = 0;
  int    reg_writes = 0;
  int    settings_run = 0;
  int    drive_on_count = 0;
  int    steer_changes = 0;

  // Simulated machine behind the random ticks
  logic [31:0] sim_ms = 32'd5000;
  int          sim_angle = 0;
  bit          sim_work = 1'b0;
  bit          sim_steer = 1'b1;

  // --------------------------------------------------------------------------
  // Drive model: one tick in, the bridge command it must produce out.
  // Updates the held guidance and switch state exactly as the unit does.
  // --------------------------------------------------------------------------
  function automatic cmd_t drive_cmd_for(tick_t t);
    cmd_t r;
    int   err, aerr, p, mag, limit, span, num, step;
    logic dir, pressed;
    r = '0;
    // a fresh message replaces everything held
    if (t.new_data) begin
      hold_on    = t.guidance;
      hold_sp    = t.setpoint;
      hold_stamp = t.stamp;
    end
    // stale data drops guidance; the age wraps modulo 2^32, so a stamp
    // in the future reads as very old
    if ((t.now_ms - hold_stamp) > {16'd0, drv_set.timeout})
      hold_on = 1'b0;

    if (hold_on) begin
      err  = int'($signed(hold_sp)) - int'($signed(t.actual));
      aerr = (err < 0) ? -err : err;
      p    = (err * int'(drv_set.gain)) / 100;   // truncates toward zero
      if (p > 32767)  p = 32767;
      if (p < -32768) p = -32768;
      mag = ((p < 0) ? -p : p) + int'(drv_set.min_duty);
      dir = (p > 1) ^ drv_set.invert;
      // limit ramps from low to high over the first five degrees; the
      // ramp may slope downwards, hence the floor on a negative product
      limit = int'(drv_set.high_duty);
      if (aerr < RAMP_CD) begin
        span = int'(drv_set.high_duty) - int'(drv_set.low_duty);
        num  = aerr * span;
        step = num / RAMP_CD;
        if (num < 0 && (num % RAMP_CD) != 0) step = step - 1;
        limit = int'(drv_set.low_duty) + step;
      end
      if (mag > limit) mag = limit;
      r.pwm_duty     = 8'(mag);
      r.drive_enable = 1'b1;
      r.dir_a        = dir;
      r.dir_b        = ~dir;
      drive_on_count++;
    end

    if (drv_set.work_mode) work_state = t.work_pin;

    if (drv_set.steer_mode == STEER_BUTTON) begin
      // toggle on a press edge, but not within the lockout of the last change
      pressed = ~t.steer_pin;
      if (pressed && !was_pressed && (t.now_ms - toggle_ms) > LOCKOUT_MS) begin
        steer_state = ~steer_state;
        toggle_ms   = t.now_ms;
        steer_changes++;
      end
      was_pressed = pressed;
    end else if (drv_set.steer_mode == STEER_SWITCH) begin
      if (t.steer_pin != steer_state) begin
        steer_state = t.steer_pin;
        toggle_ms   = t.now_ms;
        steer_changes++;
      end
    end

    r.work_bit   = work_state;
    r.steer_bit  = steer_state;
    r.angle_echo = t.actual;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers ticks from the backlog, predicts on each input transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      tx_busy = in_valid;
      if (in_valid && in_ready) begin
        cmd_due.push_back(drive_cmd_for(tick_offered));
        ticks_taken++;
        tx_busy = 1'b0;
        tx_gap  = tx_idle_en ? int'($urandom_range(0, 4)) : 0;
      end
      // an offered tick stays put until taken; only new offers are gated
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (tick_backlog.size() > 0 && !tx_pause) begin
          tick_offered         = tick_backlog.pop_front();
          in_now_ms           <= tick_offered.now_ms;
          in_new_data         <= tick_offered.new_data;
          in_data_guidance    <= tick_offered.guidance;
          in_data_setpoint_cd <= tick_offered.setpoint;
          in_data_stamp_ms    <= tick_offered.stamp;
          in_actual_angle_cd  <= tick_offered.actual;
          in_work_pin         <= tick_offered.work_pin;
          in_steer_pin        <= tick_offered.steer_pin;
          in_valid            <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each output transfer against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_pwm_duty, out_drive_enable, out_dir_a, out_dir_b,
               out_work_bit, out_steer_bit, out_angle_echo_cd};
        if (cmd_due.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: unexpected command duty=%0d en=%0b", $realtime,
                     got.pwm_duty, got.drive_enable);
        end else begin
          want = cmd_due.pop_front();
          cmds_checked++;
          if (got !== want) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("%0t: command %0d mismatch", $realtime, cmds_checked);
              $display("  want duty=%0d en=%b a=%b b=%b work=%b steer=%b angle=%0d",
                       want.pwm_duty, want.drive_enable, want.dir_a, want.dir_b,
                       want.work_bit, want.steer_bit, $signed(want.angle_echo));
              $display("  got  duty=%0d en=%b a=%b b=%b work=%b steer=%b angle=%0d",
                       got.pwm_duty, got.drive_enable, got.dir_a, got.dir_b,
                       got.work_bit, got.steer_bit, $signed(got.angle_echo));
            end
          end
        end
        rx_stall = rx_idle_en ? int'($urandom_range(0, 4)) : 0;
      end
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off timer; armed from the stimulus at a falling edge
  always @(posedge clk) begin
    if (rx_hold_left > 0) rx_hold_left <= rx_hold_left - 1;
  end

  // --------------------------------------------------------------------------
  // Register writes: one transfer on cfg_, model copy updated alongside.
  // Upper data bits beyond a register's width are junk on purpose.
  // --------------------------------------------------------------------------
  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_PROP_GAIN:  drv_set.gain       = value[7:0];
      REG_MIN_DUTY:   drv_set.min_duty   = value[7:0];
      REG_LOW_DUTY:   drv_set.low_duty   = value[7:0];
      REG_HIGH_DUTY:  drv_set.high_duty  = value[7:0];
      REG_INVERT_DIR: drv_set.invert     = value[0];
      REG_TIMEOUT_MS: drv_set.timeout    = value;
      REG_WORK_MODE:  drv_set.work_mode  = value[0];
      REG_STEER_MODE: drv_set.steer_mode = value[1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(REG_PROP_GAIN,  {8'($urandom), s.gain});
    write_reg(REG_MIN_DUTY,   {8'($urandom), s.min_duty});
    write_reg(REG_LOW_DUTY,   {8'($urandom), s.low_duty});
    write_reg(REG_HIGH_DUTY,  {8'($urandom), s.high_duty});
    write_reg(REG_INVERT_DIR, {15'($urandom), s.invert});
    write_reg(REG_TIMEOUT_MS, s.timeout);
    write_reg(REG_WORK_MODE,  {15'($urandom), s.work_mode});
    write_reg(REG_STEER_MODE, {14'($urandom), s.steer_mode});
    settings_run++;
  endtask

  function automatic setting_t random_setting();
    setting_t s;
    s = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
          16'($urandom), 1'($urandom), 2'($urandom)};
    // short timeouts are where guidance drops; favour them half the time
    if ($urandom_range(0, 1) == 0) s.timeout = 16'($urandom_range(0, 300));
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tick sources
  // --------------------------------------------------------------------------
  function automatic void queue_tick(logic [31:0] now, bit nd, bit g, int sp,
                                     logic [31:0] st, int act, bit wp, bit spin);
    tick_backlog.push_back('{now, nd, g, 16'(sp), st, 16'(act), wp, spin});
  endfunction

  // Mostly a plausible machine: 10 ms ticks, a wheel angle that drifts,
  // occasional guidance messages with setpoints near the angle, pins that
  // bounce now and then. About one tick in ten is pure noise.
  function automatic tick_t make_tick(int data_pct);
    tick_t t;
    int    delta;
    if ($urandom_range(0, 9) == 0) begin
      t = '{$urandom, 1'($urandom), 1'($urandom), 16'($urandom), $urandom,
            16'($urandom), 1'($urandom), 1'($urandom)};
      return t;
    end
    case ($urandom_range(0, 19))
      0, 1:    sim_ms = sim_ms + $urandom_range(1, 60);
      2:       sim_ms = sim_ms + $urandom_range(61, 2000);
      3:       sim_ms = $urandom;
      default: sim_ms = sim_ms + 32'd10;
    endcase
    if ($urandom_range(0, 19) == 0)
      sim_angle = int'($urandom_range(0, 36000)) - 18000;
    else
      sim_angle = sim_angle + int'($urandom_range(0, 400)) - 200;
    if (sim_angle > 18000)  sim_angle = 18000;
    if (sim_angle < -18000) sim_angle = -18000;
    if ($urandom_range(0, 9) == 0) sim_work = ~sim_work;
    if ($urandom_range(0, 3) == 0) sim_steer = ~sim_steer;

    // ignored message fields carry junk when no message is present
    t = '{sim_ms, 1'b0, 1'($urandom), 16'($urandom), $urandom,
          16'(sim_angle), sim_work, sim_steer};
    if (int'($urandom_range(0, 99)) < data_pct) begin
      case ($urandom_range(0, 4))
        0, 1:    delta = int'($urandom_range(0, 1200)) - 600;
        2, 3:    delta = int'($urandom_range(0, 10000)) - 5000;
        default: delta = int'($urandom_range(0, 36000)) - 18000 - sim_angle;
      endcase
      t.new_data = 1'b1;
      t.guidance = ($urandom_range(0, 9) != 0);
      t.setpoint = 16'(sim_angle + delta);
      if ($urandom_range(0, 7) != 0) t.stamp = sim_ms - $urandom_range(0, 30);
    end
    return t;
  endfunction

  // Waits at falling edges until every tick is taken and every command seen,
  // then keeps waiting so that the two-stage pipeline is left idle
  task automatic wait_drained();
    @(negedge clk);
    while (tick_backlog.size() != 0 || in_valid || cmd_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    setting_t s;
    int       data_pct;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: gain 255, min 10, ramp 20..200, 100 ms timeout, work pin
    // followed, button mode for the steer switch
    apply_setting('{8'd255, 8'd10, 8'd20, 8'd200, 1'b0, 16'd100, 1'b1,
                    STEER_BUTTON});
    @(negedge clk);
    queue_tick(1000, 0, 0, 0, 0, 0, 1, 1);              // no guidance yet
    queue_tick(1010, 1, 1, 1000, 1010, 0, 1, 1);        // large error, clamped
    queue_tick(1110, 0, 0, 0, 0, 995, 0, 0);            // age equals timeout; press
    queue_tick(1111, 0, 0, 0, 0, 0, 0, 1);              // one ms past: dropped
    queue_tick(1160, 0, 0, 0, 0, 0, 0, 0);              // press at exactly lockout
    queue_tick(1161, 0, 0, 0, 0, 0, 0, 1);
    queue_tick(1162, 0, 0, 0, 0, 0, 0, 0);              // press just past lockout
    queue_tick(1170, 1, 1, -32768, 1170, 32767, 1, 0);  // P saturates negative
    queue_tick(1180, 1, 1, 0, 1180, 1, 1, 1);           // small negative P
    queue_tick(1190, 1, 1, 0, 1190, 0, 0, 1);           // zero error
    queue_tick(1200, 0, 0, 0, 0, -1, 0, 1);             // P of two, forward
    queue_tick(1210, 1, 1, 32767, 1210, -32768, 1, 1);  // P saturates positive
    queue_tick(1220, 1, 0, 5000, 1220, 0, 1, 1);        // message turns guidance off
    queue_tick(1230, 1, 1, 100, 1235, 0, 1, 1);         // stamp in the future
    queue_tick(32'h10, 1, 1, 300, 32'hFFFF_FFF0, 0, 0, 1); // age across the wrap
    queue_tick(32'h30, 0, 0, 0, 0, 499, 0, 1);
    queue_tick(32'h74, 0, 0, 0, 0, 0, 0, 1);            // aged out after the wrap
    queue_tick(32'h80, 1, 1, -18000, 32'h80, 18000, 1, 1);
    queue_tick(32'h90, 1, 1, 18000, 32'h90, -18000, 1, 1);
    queue_tick(32'hA0, 1, 1, 500, 32'hA0, 0, 1, 0);     // ramp end: full limit
    queue_tick(32'hB0, 1, 1, 499, 32'hB0, 0, 1, 1);     // last step of the ramp
    queue_tick(32'hC0, 1, 1, -499, 32'hC0, 0, 1, 1);
    wait_drained();

    // Random phases over a spread of settings
    for (int k = 1; k <= 7; k++) begin
      case (k)
        1:       s = '{8'd120, 8'd30, 8'd40, 8'd220, 1'b0, 16'd500, 1'b1,
                       STEER_BUTTON};
        2:       s = '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 16'hFFFF, 1'b1,
                       STEER_SWITCH};
        3:       s = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0, 1'b0, STEER_NONE};
        4:       s = '{8'd200, 8'd5, 8'd250, 8'd10, 1'b1, 16'd200, 1'b0,
                       STEER_UNUSED};
        default: s = random_setting();
      endcase
      data_pct = (k == 3) ? 60 : int'($urandom_range(2, 40));
      apply_setting(s);
      @(negedge clk);
      // phase 2 runs flat out, 3 and 4 idle on one side only
      tx_idle_en = (k != 2 && k != 4);
      rx_idle_en = (k != 2 && k != 3);
      repeat (PHASE_TICKS) tick_backlog.push_back(make_tick(data_pct));

      if (k == 1) begin
        // receiver holds off while ticks keep coming: the unit fills up
        // and must stall its input
        rx_hold_left = HOLD_CYCLES;
      end
      if (k == 4) begin
        // sender stops mid-phase until every pending command has arrived
        while (tick_backlog.size() > PHASE_TICKS / 2) @(negedge clk);
        tx_pause = 1'b1;
        while (in_valid || cmd_due.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
        tx_pause = 1'b0;
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (cmd_due.size() != 0) begin
      fault_count++;
      $display("%0d commands never arrived", cmd_due.size());
    end
    $display("Ran %0d ticks over %0d register settings (%0d writes), %0d commands checked.",
             ticks_taken, settings_run, reg_writes, cmds_checked);
    $display("Guidance on for %0d ticks, %0d steer flag changes, %0d faults.",
             drive_on_count, steer_changes, fault_count);
    if (fault_count == 0)
      $display("steer_motor_p_drive_unit verification clean");
    else
      $display("steer_motor_p_drive_unit verification failed");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("steer_motor_p_drive_unit verification failed");
    $finish;
  end

endmodule
